// ----- hw/rtl/door_unlock_until_reed_close_defines.svh -----
// assertion macros shared by the door lock checker
`ifndef DOOR_UNLOCK_UNTIL_REED_CLOSE_DEFINES_SVH
`define DOOR_UNLOCK_UNTIL_REED_CLOSE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DUR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("door lock check failed");

// next-cycle implication, disabled while in reset
`define DUR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("door lock check failed");

`endif

// ----- hw/rtl/dur_pkg.sv -----
// types, codes and constants of the door lock controller
`default_nettype none

package dur_pkg;

    localparam int ACTION_W  = 2;
    localparam int PHASE_W   = 2;
    localparam int EVENT_W   = 3;
    localparam int TIME_W    = 20;
    localparam int HIT_W     = 8;
    localparam int POLL_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 20;

    localparam logic [TIME_W-1:0] ELAPSED_MAX = {TIME_W{1'b1}};
    localparam logic [HIT_W-1:0]  RUN_MAX     = {HIT_W{1'b1}};

    localparam logic [TIME_W-1:0] OPEN_TIMEOUT_RST = 20'd10000;
    localparam logic [TIME_W-1:0] MAX_UNLOCK_RST   = 20'd60000;
    localparam logic [HIT_W-1:0]  HIT_COUNT_RST    = 8'd3;
    localparam logic [POLL_W-1:0] POLL_RST         = 10'd20;

    typedef enum logic [ACTION_W-1:0] {
        ACT_START  = 2'd0,
        ACT_STOP   = 2'd1,
        ACT_SAMPLE = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OPEN_TIMEOUT = 2'd0,
        REG_MAX_UNLOCK   = 2'd1,
        REG_HIT_COUNT    = 2'd2,
        REG_POLL         = 2'd3
    } cfg_idx_t;

    localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_OPEN  = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_CLOSE = 2'd2;

    localparam logic [EVENT_W-1:0] EV_NONE         = 3'd0;
    localparam logic [EVENT_W-1:0] EV_STARTED      = 3'd1;
    localparam logic [EVENT_W-1:0] EV_OPEN_CONFIRM = 3'd2;
    localparam logic [EVENT_W-1:0] EV_CLOSED       = 3'd3;
    localparam logic [EVENT_W-1:0] EV_OPEN_TIMEOUT = 3'd4;
    localparam logic [EVENT_W-1:0] EV_MAX_OR_STOP  = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_OPEN  = 3'b010,
        PH_CLOSE = 3'b100
    } phase_t;

    typedef struct packed {
        logic [TIME_W-1:0] open_timeout_ms;
        logic [TIME_W-1:0] max_unlock_ms;
        logic [HIT_W-1:0]  hit_count_needed;
        logic [POLL_W-1:0] poll_ms;
    } cfg_t;

    typedef struct packed {
        logic               unlocked;
        logic [PHASE_W-1:0] phase;
        logic [EVENT_W-1:0] event_res;
    } result_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        unique case (ph)
            PH_OPEN:  code = PHASE_CODE_OPEN;
            PH_CLOSE: code = PHASE_CODE_CLOSE;
            default:  code = PHASE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dur_sample_if.sv -----
// sample channel: command or reed switch sample beats
`default_nettype none

interface dur_sample_if;
    import dur_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic                reed_closed;

    modport source (output valid, output action, output reed_closed, input ready);
    modport sink (input valid, input action, input reed_closed, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dur_result_if.sv -----
// result channel: lock drive, phase and event beats
`default_nettype none

interface dur_result_if;
    import dur_pkg::*;

    logic               valid;
    logic               ready;
    logic               unlocked;
    logic [PHASE_W-1:0] phase;
    logic [EVENT_W-1:0] event_res;

    modport source (output valid, output unlocked, output phase, output event_res, input ready);
    modport sink (input valid, input unlocked, input phase, input event_res, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dur_cfg_regs.sv -----
// configuration register bank of the door lock controller
`default_nettype none

module dur_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [dur_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dur_pkg::CFG_W-1:0]      cfg_wdata,
    output dur_pkg::cfg_t                       cfg
);
    import dur_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_timeout_ms  <= OPEN_TIMEOUT_RST;
            cfg_reg.max_unlock_ms    <= MAX_UNLOCK_RST;
            cfg_reg.hit_count_needed <= HIT_COUNT_RST;
            cfg_reg.poll_ms          <= POLL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_OPEN_TIMEOUT: cfg_reg.open_timeout_ms  <= cfg_wdata[TIME_W-1:0];
                REG_MAX_UNLOCK:   cfg_reg.max_unlock_ms    <= cfg_wdata[TIME_W-1:0];
                REG_HIT_COUNT:    cfg_reg.hit_count_needed <= cfg_wdata[HIT_W-1:0];
                REG_POLL:         cfg_reg.poll_ms          <= cfg_wdata[POLL_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dur_ctrl.sv -----
// phase state, debounce run counter and phase timer
`default_nettype none

module dur_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dur_pkg::cfg_t                 cfg,
    input  wire logic                          accept,
    input  wire logic [dur_pkg::ACTION_W-1:0]  action,
    input  wire logic                          reed_closed,
    output dur_pkg::result_t                   res_next
);
    import dur_pkg::*;

    phase_t            phase_reg, phase_next;
    logic              saw_closed_reg, saw_closed_next;
    logic [HIT_W-1:0]  run_reg, run_next;
    logic [TIME_W-1:0] elapsed_reg, elapsed_next;

    logic [HIT_W-1:0]  run_bumped;
    logic [TIME_W:0]   timer_sum;
    logic [TIME_W-1:0] timer_adv;
    logic              restart;
    logic [EVENT_W-1:0] ev;

    assign run_bumped = (run_reg == RUN_MAX) ? run_reg : run_reg + 8'd1;
    assign timer_sum  = {1'b0, elapsed_reg} + {{(TIME_W + 1 - POLL_W){1'b0}}, cfg.poll_ms};
    assign timer_adv  = timer_sum[TIME_W] ? ELAPSED_MAX : timer_sum[TIME_W-1:0];

    always_comb
    begin
        phase_next      = phase_reg;
        saw_closed_next = saw_closed_reg;
        run_next        = run_reg;
        elapsed_next    = elapsed_reg;
        restart         = 1'b0;
        ev              = EV_NONE;

        unique case (action_t'(action))
            ACT_START:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    phase_next = PH_OPEN;
                    restart    = 1'b1;
                    ev         = EV_STARTED;
                end
            end
            ACT_STOP:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    phase_next = PH_IDLE;
                    restart    = 1'b1;
                    ev         = EV_MAX_OR_STOP;
                end
            end
            ACT_SAMPLE:
            begin
                unique case (phase_reg)
                    PH_OPEN:
                    begin
                        if (elapsed_reg >= cfg.open_timeout_ms)
                        begin
                            phase_next = PH_IDLE;
                            restart    = 1'b1;
                            ev         = EV_OPEN_TIMEOUT;
                        end
                        else if (elapsed_reg >= cfg.max_unlock_ms)
                        begin
                            phase_next = PH_IDLE;
                            restart    = 1'b1;
                            ev         = EV_MAX_OR_STOP;
                        end
                        else if (reed_closed)
                        begin
                            saw_closed_next = 1'b1;
                            run_next        = '0;
                            elapsed_next    = timer_adv;
                        end
                        else if (saw_closed_reg)
                        begin
                            run_next = run_bumped;
                            if (run_bumped >= cfg.hit_count_needed)
                            begin
                                phase_next = PH_CLOSE;
                                restart    = 1'b1;
                                ev         = EV_OPEN_CONFIRM;
                            end
                            else
                            begin
                                elapsed_next = timer_adv;
                            end
                        end
                        else
                        begin
                            run_next     = '0;
                            elapsed_next = timer_adv;
                        end
                    end
                    PH_CLOSE:
                    begin
                        if (elapsed_reg >= cfg.max_unlock_ms)
                        begin
                            phase_next = PH_IDLE;
                            restart    = 1'b1;
                            ev         = EV_MAX_OR_STOP;
                        end
                        else if (reed_closed)
                        begin
                            run_next = run_bumped;
                            if (run_bumped >= cfg.hit_count_needed)
                            begin
                                phase_next = PH_IDLE;
                                restart    = 1'b1;
                                ev         = EV_CLOSED;
                            end
                            else
                            begin
                                elapsed_next = timer_adv;
                            end
                        end
                        else
                        begin
                            run_next     = '0;
                            elapsed_next = timer_adv;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        // entering a phase clears its bookkeeping
        if (restart)
        begin
            saw_closed_next = 1'b0;
            run_next        = '0;
            elapsed_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            saw_closed_reg <= 1'b0;
            run_reg        <= '0;
            elapsed_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            saw_closed_reg <= saw_closed_next;
            run_reg        <= run_next;
            elapsed_reg    <= elapsed_next;
        end
    end

    assign res_next.unlocked  = (phase_next != PH_IDLE);
    assign res_next.phase     = phase_code(phase_next);
    assign res_next.event_res = ev;

endmodule

`default_nettype wire

// ----- hw/rtl/dur_out_stage.sv -----
// result register with valid/ready toward the result channel
`default_nettype none

module dur_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire dur_pkg::result_t res_next,
    output logic                  free,
    dur_result_if.source          result_ch
);
    import dur_pkg::*;

    result_t result_reg;
    logic    valid_reg;

    assign free = !valid_reg || result_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= res_next;
        end
    end

    assign result_ch.valid     = valid_reg;
    assign result_ch.unlocked  = result_reg.unlocked;
    assign result_ch.phase     = result_reg.phase;
    assign result_ch.event_res = result_reg.event_res;

endmodule

`default_nettype wire

// ----- hw/rtl/door_unlock_until_reed_close.sv -----
// top level of the reed switch driven door lock controller
//
// sample_ch carries one beat per command or reed sample: action 0 starts an
// unlock, 1 stops and locks, 2 is a reed sample with reed_closed. every beat
// yields exactly one beat on result_ch with the lock drive after the beat,
// the phase and the event code.
// configuration goes through cfg_we / cfg_index / cfg_wdata, one register per
// write; the user writes only while no beat is in flight, which the block
// does not enforce. a beat's result is registered at the edge that accepts it.
// throughput is one beat per cycle while result_ch is ready, set by the single
// result register that the phase logic feeds.
// reset leaves the door locked in the idle phase, configuration at its
// defaults and result_ch empty.
// when result_ch stalls, the pending result holds and sample_ch.ready drops
// until that result is taken; ready is high again in the cycle it is taken.
`default_nettype none

module door_unlock_until_reed_close (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [dur_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dur_pkg::CFG_W-1:0]     cfg_wdata,
    dur_sample_if.sink                         sample_ch,
    dur_result_if.source                       result_ch
);
    import dur_pkg::*;

    cfg_t    cfg;
    result_t res_next;
    logic    free;
    logic    accept;

    assign sample_ch.ready = free;
    assign accept          = sample_ch.valid && free;

    dur_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dur_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .action      (sample_ch.action),
        .reed_closed (sample_ch.reed_closed),
        .res_next    (res_next)
    );

    dur_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res_next  (res_next),
        .free      (free),
        .result_ch (result_ch)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/dur_checker.sv -----
// port level checks of the door lock controller and their bind
`default_nettype none
`include "door_unlock_until_reed_close_defines.svh"

module dur_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          sample_ready,
    input wire logic                          result_valid,
    input wire logic                          result_ready,
    input wire logic                          unlocked,
    input wire logic [dur_pkg::PHASE_W-1:0]   phase,
    input wire logic [dur_pkg::EVENT_W-1:0]   event_res
);
    import dur_pkg::*;

    // lock drive follows the phase
    `DUR_ASSERT_NOW(a_unlock_phase, clk, rst_n, result_valid, unlocked == (phase != PHASE_CODE_IDLE))

    // a start always lands in open-wait
    `DUR_ASSERT_NOW(a_start_open, clk, rst_n, result_valid && event_res == EV_STARTED, phase == PHASE_CODE_OPEN)

    // every locking event leaves the block idle
    `DUR_ASSERT_NOW(a_lock_idle, clk, rst_n, result_valid && (event_res == EV_CLOSED || event_res == EV_OPEN_TIMEOUT || event_res == EV_MAX_OR_STOP), phase == PHASE_CODE_IDLE)

    // input backpressure only while a result is stalled
    `DUR_ASSERT_NOW(a_ready_stall, clk, rst_n, !sample_ready, result_valid && !result_ready)

    // a stalled result holds
    `DUR_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(unlocked) && $stable(phase) && $stable(event_res))

endmodule

bind door_unlock_until_reed_close dur_checker u_dur_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_ready (sample_ch.ready),
    .result_valid (result_ch.valid),
    .result_ready (result_ch.ready),
    .unlocked     (result_ch.unlocked),
    .phase        (result_ch.phase),
    .event_res    (result_ch.event_res)
);

`default_nettype wire

// ----- test/door_unlock_until_reed_close_test.sv -----
// self-checking testbench for the reed switch driven door lock controller
`timescale 1ns / 1ps

module door_unlock_until_reed_close_test;
    import dur_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 12;
    localparam int WAIT_MAX = 14;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic                closed;
    } lock_cmd_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    dur_sample_if sample_ch();
    dur_result_if result_ch();

    door_unlock_until_reed_close i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample_ch (sample_ch),
        .result_ch (result_ch)
    );

    // shadow of the lock controller
    cfg_t               lock_cfg;
    logic [PHASE_W-1:0] lock_phase;
    logic               lock_saw_closed;
    logic [HIT_W-1:0]   lock_run;
    logic [TIME_W-1:0]  lock_elapsed;

    lock_cmd_t lock_cmds[$];
    result_t   lock_expect[$];

    int  mismatches = 0;
    int  cmds_pushed = 0;
    int  send_max = WAIT_MAX;
    int  recv_max = WAIT_MAX;
    int  send_wait = 0;
    int  recv_wait = 0;
    int  hold_left = 0;
    bit  hold_req = 0;
    bit  cmd_on_bus = 0;
    bit  beat_in = 0;
    bit  beat_out = 0;

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int draw_wait(input int lim);
        if (lim == 0 || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, lim);
    endfunction

    function automatic void go_phase(input logic [PHASE_W-1:0] ph);
        lock_phase = ph;
        lock_saw_closed = 1'b0;
        lock_run = '0;
        lock_elapsed = '0;
    endfunction

    function automatic void tick_timer();
        logic [TIME_W:0] sum;
        sum = {1'b0, lock_elapsed} + {{(TIME_W + 1 - POLL_W){1'b0}}, lock_cfg.poll_ms};
        lock_elapsed = (sum > ELAPSED_MAX) ? ELAPSED_MAX : sum[TIME_W-1:0];
    endfunction

    function automatic void count_match();
        if (lock_run != RUN_MAX)
            lock_run = lock_run + 8'd1;
    endfunction

    function automatic result_t next_lock_result(input logic [ACTION_W-1:0] act,
                                                 input logic closed);
        logic [EVENT_W-1:0] ev;
        result_t            r;
        ev = EV_NONE;
        case (act)
            ACT_START:
            begin
                if (lock_phase == PHASE_CODE_IDLE)
                begin
                    go_phase(PHASE_CODE_OPEN);
                    ev = EV_STARTED;
                end
            end
            ACT_STOP:
            begin
                if (lock_phase != PHASE_CODE_IDLE)
                begin
                    go_phase(PHASE_CODE_IDLE);
                    ev = EV_MAX_OR_STOP;
                end
            end
            ACT_SAMPLE:
            begin
                if (lock_phase == PHASE_CODE_OPEN)
                begin
                    if (lock_elapsed >= lock_cfg.open_timeout_ms)
                    begin
                        go_phase(PHASE_CODE_IDLE);
                        ev = EV_OPEN_TIMEOUT;
                    end
                    else if (lock_elapsed >= lock_cfg.max_unlock_ms)
                    begin
                        go_phase(PHASE_CODE_IDLE);
                        ev = EV_MAX_OR_STOP;
                    end
                    else if (closed)
                    begin
                        lock_saw_closed = 1'b1;
                        lock_run = '0;
                        tick_timer();
                    end
                    else if (lock_saw_closed)
                    begin
                        count_match();
                        if (lock_run >= lock_cfg.hit_count_needed)
                        begin
                            go_phase(PHASE_CODE_CLOSE);
                            ev = EV_OPEN_CONFIRM;
                        end
                        else
                            tick_timer();
                    end
                    else
                    begin
                        lock_run = '0;
                        tick_timer();
                    end
                end
                else if (lock_phase == PHASE_CODE_CLOSE)
                begin
                    if (lock_elapsed >= lock_cfg.max_unlock_ms)
                    begin
                        go_phase(PHASE_CODE_IDLE);
                        ev = EV_MAX_OR_STOP;
                    end
                    else if (closed)
                    begin
                        count_match();
                        if (lock_run >= lock_cfg.hit_count_needed)
                        begin
                            go_phase(PHASE_CODE_IDLE);
                            ev = EV_CLOSED;
                        end
                        else
                            tick_timer();
                    end
                    else
                    begin
                        lock_run = '0;
                        tick_timer();
                    end
                end
            end
            default: ;
        endcase
        r.unlocked = (lock_phase != PHASE_CODE_IDLE);
        r.phase = lock_phase;
        r.event_res = ev;
        return r;
    endfunction

    // monitor: check result beats, predict accepted command beats
    always @(posedge clk)
    begin
        result_t want;
        beat_in = sample_ch.valid && sample_ch.ready;
        beat_out = result_ch.valid && result_ch.ready;
        if (rst_n)
        begin
            if (beat_out)
            begin
                if (lock_expect.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    want = lock_expect.pop_front();
                    if (result_ch.unlocked !== want.unlocked)
                        report_mismatch($sformatf("unlocked got %b expected %b",
                                                  result_ch.unlocked, want.unlocked));
                    if (result_ch.phase !== want.phase)
                        report_mismatch($sformatf("phase got %0d expected %0d",
                                                  result_ch.phase, want.phase));
                    if (result_ch.event_res !== want.event_res)
                        report_mismatch($sformatf("event_res got %0d expected %0d",
                                                  result_ch.event_res, want.event_res));
                end
                recv_wait = draw_wait(recv_max);
            end
            if (beat_in)
            begin
                lock_expect.push_back(next_lock_result(sample_ch.action,
                                                       sample_ch.reed_closed));
                cmd_on_bus = 0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 0;
        end
        else if (hold_left != 0)
            hold_left--;
    end

    // driver
    always @(negedge clk)
    begin
        lock_cmd_t cmd;
        if (rst_n && (!sample_ch.valid || beat_in))
        begin
            if (send_wait != 0)
            begin
                send_wait--;
                sample_ch.valid <= 1'b0;
            end
            else if (lock_cmds.size() != 0)
            begin
                cmd = lock_cmds.pop_front();
                cmd_on_bus = 1;
                sample_ch.action <= cmd.act;
                sample_ch.reed_closed <= cmd.closed;
                sample_ch.valid <= 1'b1;
                send_wait = draw_wait(send_max);
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
                result_ch.ready <= 1'b0;
            else if (recv_wait != 0)
            begin
                recv_wait--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    task automatic push_cmd(input logic [ACTION_W-1:0] act, input logic closed);
        lock_cmd_t cmd;
        cmd.act = act;
        cmd.closed = closed;
        lock_cmds.push_back(cmd);
        cmds_pushed++;
    endtask

    task automatic push_noisy(input logic want_closed);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            push_cmd(ACT_STOP, 1'($urandom_range(0, 1)));
        else if (r < 5)
            push_cmd(ACT_START, 1'($urandom_range(0, 1)));
        else if (r < 7)
            push_cmd(ACT_UNUSED, 1'($urandom_range(0, 1)));
        else if ($urandom_range(0, 9) == 0)
            push_cmd(ACT_SAMPLE, !want_closed);
        else
            push_cmd(ACT_SAMPLE, want_closed);
    endtask

    // start, a few closed, a run of open, a run of closed, now and then a stop; some sessions are random beats instead
    task automatic add_sessions(input int hit, input int count);
        int first;
        first = cmds_pushed;
        while (cmds_pushed - first < count)
        begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4))
                    push_cmd(ACTION_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            else
            begin
                push_cmd(ACT_START, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 3))
                    push_noisy(1'b1);
                repeat ($urandom_range(0, hit + 2))
                    push_noisy(1'b0);
                repeat ($urandom_range(0, hit + 2))
                    push_noisy(1'b1);
                if ($urandom_range(0, 7) == 0)
                    push_cmd(ACT_STOP, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (lock_cmds.size() != 0 || cmd_on_bus || lock_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            REG_OPEN_TIMEOUT: lock_cfg.open_timeout_ms = val[TIME_W-1:0];
            REG_MAX_UNLOCK:   lock_cfg.max_unlock_ms = val[TIME_W-1:0];
            REG_HIT_COUNT:    lock_cfg.hit_count_needed = val[HIT_W-1:0];
            REG_POLL:         lock_cfg.poll_ms = val[POLL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_lock_cfg(input int open_to, input int max_to, input int hit,
                                input int poll, input int smax, input int rmax);
        wait_drained();
        write_reg(REG_OPEN_TIMEOUT, CFG_W'(open_to));
        write_reg(REG_MAX_UNLOCK, CFG_W'(max_to));
        write_reg(REG_HIT_COUNT, CFG_W'(hit));
        write_reg(REG_POLL, CFG_W'(poll));
        @(negedge clk);
        cfg_we = 1'b0;
        send_max = smax;
        recv_max = rmax;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        sample_ch.valid = 1'b0;
        sample_ch.action = ACT_START;
        sample_ch.reed_closed = 1'b0;
        result_ch.ready = 1'b0;
        lock_cfg.open_timeout_ms = OPEN_TIMEOUT_RST;
        lock_cfg.max_unlock_ms = MAX_UNLOCK_RST;
        lock_cfg.hit_count_needed = HIT_COUNT_RST;
        lock_cfg.poll_ms = POLL_RST;
        go_phase(PHASE_CODE_IDLE);
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed walk through one full unlock cycle at the reset settings
        set_lock_cfg(int'(OPEN_TIMEOUT_RST), int'(MAX_UNLOCK_RST), int'(HIT_COUNT_RST),
                     int'(POLL_RST), WAIT_MAX, WAIT_MAX);
        push_cmd(ACT_SAMPLE, 1'b1);
        push_cmd(ACT_STOP, 1'b0);
        push_cmd(ACT_UNUSED, 1'b1);
        push_cmd(ACT_START, 1'b0);
        push_cmd(ACT_START, 1'b1);
        push_cmd(ACT_SAMPLE, 1'b0);
        push_cmd(ACT_SAMPLE, 1'b1);
        push_cmd(ACT_SAMPLE, 1'b0);
        push_cmd(ACT_SAMPLE, 1'b1);
        repeat (3) push_cmd(ACT_SAMPLE, 1'b0);
        push_cmd(ACT_SAMPLE, 1'b1);
        push_cmd(ACT_UNUSED, 1'b0);
        push_cmd(ACT_SAMPLE, 1'b0);
        repeat (3) push_cmd(ACT_SAMPLE, 1'b1);
        push_cmd(ACT_START, 1'b0);
        push_cmd(ACT_STOP, 1'b1);
        push_cmd(ACT_SAMPLE, 1'b0);

        // open timeout well before the safety limit
        set_lock_cfg(200, 400, 3, 20, WAIT_MAX, WAIT_MAX);
        add_sessions(3, 180);
        // safety limit before the open timeout
        set_lock_cfg(int'(ELAPSED_MAX), 100, 2, 20, WAIT_MAX, WAIT_MAX);
        add_sessions(2, 170);
        // zero limits time out on every sample
        set_lock_cfg(0, 0, 1, 1, WAIT_MAX, 0);
        add_sessions(1, 80);
        // timer runs into saturation
        set_lock_cfg(int'(ELAPSED_MAX), int'(ELAPSED_MAX), int'(RUN_MAX), 1000, 3, 3);
        push_cmd(ACT_START, 1'b0);
        repeat (1060) push_cmd(ACT_SAMPLE, 1'($urandom_range(0, 1)));
        // zero hit count and frozen timer
        set_lock_cfg(5000, 5000, 0, 0, 0, WAIT_MAX);
        add_sessions(1, 150);
        // back-pressure: no idling, long receiver hold, then sender pause
        set_lock_cfg(int'(OPEN_TIMEOUT_RST), int'(MAX_UNLOCK_RST), int'(HIT_COUNT_RST),
                     int'(POLL_RST), 0, 0);
        hold_req = 1;
        add_sessions(3, 80);
        wait_drained();
        send_max = WAIT_MAX;
        recv_max = WAIT_MAX;
        add_sessions(3, 70);
        // arbitrary settings
        set_lock_cfg($urandom_range(0, 2000), $urandom_range(0, 2000),
                     $urandom_range(1, 8), $urandom_range(1, 1000), WAIT_MAX, WAIT_MAX);
        add_sessions(5, 100);

        wait_drained();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/dur_pkg.sv
hw/rtl/dur_sample_if.sv
hw/rtl/dur_result_if.sv
hw/rtl/dur_cfg_regs.sv
hw/rtl/dur_ctrl.sv
hw/rtl/dur_out_stage.sv
hw/rtl/door_unlock_until_reed_close.sv
hw/rtl/dur_checker.sv
test/door_unlock_until_reed_close_test.sv
